// File: hdl/cv3_pkg.sv
`default_nettype none

package cv3_pkg;

    // sizes
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int NUM_CH        = 3;
    localparam int CH_W          = 8;
    localparam int PX_W          = NUM_CH * CH_W;
    localparam int KDIM          = 3;
    localparam int COEF_W        = 13;
    localparam int KROW_W        = KDIM * COEF_W;
    localparam int WIDTH_REG_W   = 11;
    localparam int HEIGHT_W      = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = KROW_W;
    localparam int PROD_W        = COEF_W + CH_W + 1;
    localparam int ROW_SUM_W     = PROD_W + 1;
    localparam int SUM_W         = 25;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_KERNEL_TOP    = 3'd2,
        CFG_KERNEL_MIDDLE = 3'd3,
        CFG_KERNEL_BOTTOM = 3'd4
    } t_cfg_idx;

    // packed rgb pixel, red in the low byte
    typedef logic [PX_W-1:0] t_pixel;
    typedef t_pixel   [KDIM-1:0] t_win_row;
    typedef t_win_row [KDIM-1:0] t_window;

    typedef logic signed [ROW_SUM_W-1:0] t_row_sum;
    typedef t_row_sum [NUM_CH-1:0] t_lane_sums;

    // window item handed from the front end to the lanes
    typedef struct packed {
        logic    valid;
        logic    frame_end;
        t_window win;
    } t_win_item;

    // load enables for the lane registers
    typedef struct packed {
        logic p_ld;
        logic s_ld;
    } t_lane_ctl;

endpackage

`default_nettype wire

// File: hdl/conv3x3_rgb_zero_padded_unit.sv
// each result passes the scan, window, product, row-sum and merge output registers in turn
// throughput: one item per cycle unless back-pressure stalls it; each item reads both line
// memories on accept and writes them on leaving stage one, via separate read and write ports
// reset: i_rst_n synchronous, active low; clears the scan position, window and stage
// valids, and sets width 1, height 1 and an all-zero kernel
// line memories are not cleared and are written by the first row of each frame before use
`default_nettype none

module conv3x3_rgb_zero_padded_unit import cv3_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [CH_W-1:0]       i_red,
    input  wire logic [CH_W-1:0]       i_green,
    input  wire logic [CH_W-1:0]       i_blue,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic signed [SUM_W-1:0]    o_red_sum,
    output logic signed [SUM_W-1:0]    o_green_sum,
    output logic signed [SUM_W-1:0]    o_blue_sum,
    output logic                       o_frame_end
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int WW = (CW > WIDTH_REG_W) ? CW : WIDTH_REG_W;

    logic [WIDTH_REG_W-1:0] r_width;
    logic [HEIGHT_W-1:0]    r_height;
    logic [KROW_W-1:0]      r_krow [KDIM];
    logic [WW-1:0]          width_eff;
    logic [HEIGHT_W-1:0]    height_eff;
    t_win_item              item;
    t_lane_ctl              lane_ctl;
    t_lane_sums             lane_sums [KDIM];
    logic                   r_p_v, r_l_v, r_o_v, r_p_fe, r_l_fe;
    logic                   take_p, take_l, take_out, out_ld;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_REG_W'(1);
            r_height <= HEIGHT_W'(1);
            for (int k = 0; k < KDIM; k++) begin
                r_krow[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:   r_width   <= i_cfg_data[WIDTH_REG_W-1:0];
                CFG_IMAGE_HEIGHT:  r_height  <= i_cfg_data[HEIGHT_W-1:0];
                CFG_KERNEL_TOP:    r_krow[0] <= i_cfg_data[KROW_W-1:0];
                CFG_KERNEL_MIDDLE: r_krow[1] <= i_cfg_data[KROW_W-1:0];
                CFG_KERNEL_BOTTOM: r_krow[2] <= i_cfg_data[KROW_W-1:0];
                default: ;
            endcase
        end
    end

    // width clamped to 1..MAX_WIDTH, height of zero taken as one
    always_comb begin
        if (r_width == '0) begin
            width_eff = WW'(1);
        end else if (WW'(r_width) > WW'(MAX_WIDTH)) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(r_width);
        end
        height_eff = (r_height == '0) ? HEIGHT_W'(1) : r_height;
    end

    // stage handshakes behind the window
    assign take_out = !r_o_v || i_ready;
    assign take_l   = !r_l_v || take_out;
    assign take_p   = !r_p_v || take_l;
    assign lane_ctl.p_ld = item.valid && take_p;
    assign lane_ctl.s_ld = r_p_v && take_l;
    assign out_ld   = r_l_v && take_out;

    cv3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_width_eff  (width_eff),
        .i_height_eff (height_eff),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_take_next  (take_p),
        .o_item       (item)
    );

    // one lane per kernel row
    for (genvar k = 0; k < KDIM; k++) begin : g_lane
        cv3_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (lane_ctl),
            .i_krow (r_krow[k]),
            .i_row  (item.win[k]),
            .o_sums (lane_sums[k])
        );
    end

    cv3_merge u_merge (
        .i_clk       (i_clk),
        .i_ld        (out_ld),
        .i_top       (lane_sums[0]),
        .i_mid       (lane_sums[1]),
        .i_bot       (lane_sums[2]),
        .i_frame_end (r_l_fe),
        .o_red_sum   (o_red_sum),
        .o_green_sum (o_green_sum),
        .o_blue_sum  (o_blue_sum),
        .o_frame_end (o_frame_end)
    );

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_l_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (take_p) begin
                r_p_v <= item.valid;
            end
            if (take_l) begin
                r_l_v <= r_p_v;
            end
            if (take_out) begin
                r_o_v <= r_l_v;
            end
        end
    end

    // frame end travels with the item
    always_ff @(posedge i_clk) begin
        if (lane_ctl.p_ld) begin
            r_p_fe <= item.frame_end;
        end
        if (lane_ctl.s_ld) begin
            r_l_fe <= r_p_fe;
        end
    end

    assign o_valid = r_o_v;

endmodule

`default_nettype wire

// File: hdl/cv3_ram.sv
`default_nettype none

module cv3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/cv3_front.sv
`default_nettype none

module cv3_front import cv3_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int CW = $clog2(MAX_WIDTH + 1),
    localparam int WW = (CW > WIDTH_REG_W) ? CW : WIDTH_REG_W
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [WW-1:0]       i_width_eff,
    input  wire logic [HEIGHT_W-1:0] i_height_eff,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [CH_W-1:0]     i_red,
    input  wire logic [CH_W-1:0]     i_green,
    input  wire logic [CH_W-1:0]     i_blue,
    input  wire logic                i_take_next,
    output t_win_item                o_item
);

    typedef struct packed {
        logic dcol;
        logic first_col;
        logic row_ge1;
        logic row_ge2;
        logic emit;
        logic frame_end;
    } t_scan_flags;

    logic [CW-1:0]       r_col, n_col;
    logic [HEIGHT_W-1:0] r_row, n_row;
    logic                dcol, drow;
    t_scan_flags         flags, r_s1_flags;
    t_pixel              cur, r_s1_cur;
    logic [AW-1:0]       r_s1_addr;
    logic                r_s1_v, r_s2_v, r_s2_fe;
    logic                take_s1, take_s2, accept, s1_go, ram_we;
    t_pixel              rd_a, rd_b, above, above2;
    t_window             r_win, n_win;

    // scan position classification
    assign dcol = WW'(r_col) >= i_width_eff;
    assign drow = r_row >= i_height_eff;

    always_comb begin
        flags.dcol      = dcol;
        flags.first_col = (r_col == '0);
        flags.row_ge1   = (r_row != '0);
        flags.row_ge2   = (r_row > HEIGHT_W'(1));
        flags.emit      = (r_row != '0) && (r_col != '0);
        flags.frame_end = dcol && drow;
    end

    assign cur = (dcol || drow) ? '0 : {i_blue, i_green, i_red};

    // next scan position
    always_comb begin
        if (dcol) begin
            n_col = '0;
            n_row = drow ? '0 : r_row + HEIGHT_W'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    // stage handshakes
    assign take_s2 = !r_s2_v || i_take_next;
    assign take_s1 = !r_s1_v || take_s2;
    assign accept  = i_valid && take_s1;
    assign s1_go   = r_s1_v && take_s2;
    assign ram_we  = s1_go && !r_s1_flags.dcol;
    assign o_ready = take_s1;

    // line memories: a holds the row above, b the row above that
    cv3_ram #(
        .WIDTH (PX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_addr),
        .i_wdata (r_s1_cur),
        .i_re    (accept),
        .i_raddr (r_col[AW-1:0]),
        .o_rdata (rd_a)
    );

    cv3_ram #(
        .WIDTH (PX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_addr),
        .i_wdata (rd_a),
        .i_re    (accept),
        .i_raddr (r_col[AW-1:0]),
        .o_rdata (rd_b)
    );

    assign above  = (!r_s1_flags.dcol && r_s1_flags.row_ge1) ? rd_a : '0;
    assign above2 = (!r_s1_flags.dcol && r_s1_flags.row_ge2) ? rd_b : '0;

    // window shift, left padding cleared at the first column
    always_comb begin
        for (int i = 0; i < KDIM; i++) begin
            if (r_s1_flags.first_col) begin
                n_win[i][0] = '0;
                n_win[i][1] = '0;
            end else begin
                n_win[i][0] = r_win[i][1];
                n_win[i][1] = r_win[i][2];
            end
        end
        n_win[0][2] = above2;
        n_win[1][2] = above;
        n_win[2][2] = r_s1_cur;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_win  <= '0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (take_s1) begin
                r_s1_v <= i_valid;
            end
            if (take_s2) begin
                r_s2_v <= r_s1_v && r_s1_flags.emit;
            end
            if (s1_go) begin
                r_win <= n_win;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_flags <= flags;
            r_s1_cur   <= cur;
            r_s1_addr  <= r_col[AW-1:0];
        end
        if (s1_go) begin
            r_s2_fe <= r_s1_flags.frame_end;
        end
    end

    assign o_item.valid     = r_s2_v;
    assign o_item.frame_end = r_s2_fe;
    assign o_item.win       = r_win;

endmodule

`default_nettype wire

// File: hdl/cv3_lane.sv
`default_nettype none

module cv3_lane import cv3_pkg::*; (
    input  wire logic              i_clk,
    input  wire t_lane_ctl         i_ctl,
    input  wire logic [KROW_W-1:0] i_krow,
    input  wire t_win_row          i_row,
    output t_lane_sums             o_sums
);

    logic signed [PROD_W-1:0]    r_prod [NUM_CH][KDIM];
    logic signed [PROD_W-1:0]    n_prod [NUM_CH][KDIM];
    logic signed [ROW_SUM_W-1:0] r_sum  [NUM_CH];
    logic signed [ROW_SUM_W-1:0] n_sum  [NUM_CH];

    // coefficient times sample, one product per channel and column
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            for (int j = 0; j < KDIM; j++) begin
                n_prod[ch][j] = PROD_W'($signed(i_krow[j*COEF_W +: COEF_W]))
                              * PROD_W'($signed({1'b0, i_row[j][ch*CH_W +: CH_W]}));
            end
        end
    end

    // row sum per channel
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            n_sum[ch] = ROW_SUM_W'(r_prod[ch][0]) + ROW_SUM_W'(r_prod[ch][1])
                      + ROW_SUM_W'(r_prod[ch][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.p_ld) begin
            r_prod <= n_prod;
        end
        if (i_ctl.s_ld) begin
            r_sum <= n_sum;
        end
    end

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            o_sums[ch] = r_sum[ch];
        end
    end

endmodule

`default_nettype wire

// File: hdl/cv3_merge.sv
`default_nettype none

module cv3_merge import cv3_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_ld,
    input  wire t_lane_sums         i_top,
    input  wire t_lane_sums         i_mid,
    input  wire t_lane_sums         i_bot,
    input  wire logic               i_frame_end,
    output logic signed [SUM_W-1:0] o_red_sum,
    output logic signed [SUM_W-1:0] o_green_sum,
    output logic signed [SUM_W-1:0] o_blue_sum,
    output logic                    o_frame_end
);

    logic signed [SUM_W-1:0] r_sum [NUM_CH];
    logic signed [SUM_W-1:0] n_sum [NUM_CH];
    logic                    r_fe;

    // add the three kernel rows per channel
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            n_sum[ch] = SUM_W'($signed(i_top[ch])) + SUM_W'($signed(i_mid[ch]))
                      + SUM_W'($signed(i_bot[ch]));
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_sum <= n_sum;
            r_fe  <= i_frame_end;
        end
    end

    assign o_red_sum   = r_sum[0];
    assign o_green_sum = r_sum[1];
    assign o_blue_sum  = r_sum[2];
    assign o_frame_end = r_fe;

endmodule

`default_nettype wire

// File: hdl/cv3_checker.sv
`default_nettype none

module cv3_checker import cv3_pkg::*; (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    o_ready,
    input wire logic                    o_valid,
    input wire logic                    i_ready,
    input wire logic signed [SUM_W-1:0] o_red_sum,
    input wire logic signed [SUM_W-1:0] o_green_sum,
    input wire logic signed [SUM_W-1:0] o_blue_sum,
    input wire logic                    o_frame_end
);

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result item shown straight after reset");

    // with no result waiting the pipeline has room for an item
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with an empty output stage");

    // a result being taken frees the whole chain
    a_ready_when_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |-> o_ready)
        else $error("input stalled while the output drains");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_red_sum) && $stable(o_green_sum)
                                   && $stable(o_blue_sum) && $stable(o_frame_end)))
        else $error("stalled result item changed");

endmodule

bind conv3x3_rgb_zero_padded_unit cv3_checker u_checker (.*);

`default_nettype wire
